[rtl/core/lse_pkg.sv]
package lse_pkg;

  localparam int FUNC_W     = 2;
  localparam int COORD_W    = 4;
  localparam int SPIN_W     = 2;
  localparam int SIZE_W     = 5;
  localparam int K_W        = 16;
  localparam int ENERGY_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register indexes on the config port
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COUPLING_K = 2'd3;

  localparam logic [SIZE_W-1:0] SIZE_X_RST = 5'd16;
  localparam logic [SIZE_W-1:0] SIZE_Y_RST = 5'd16;
  localparam logic [SIZE_W-1:0] SIZE_Z_RST = 5'd1;

  // +1.0 in Q12.8, energy width
  localparam logic signed [ENERGY_W-1:0] Q_ONE = 20'sd256;

  localparam logic signed [SPIN_W-1:0] SPIN_POS  = 2'sb01;
  localparam logic signed [SPIN_W-1:0] SPIN_ZERO = 2'sb00;
  localparam logic signed [SPIN_W-1:0] SPIN_NEG  = 2'sb11;

  typedef enum logic [FUNC_W-1:0] {
    FN_WRITE  = 2'd0,
    FN_ENERGY = 2'd1,
    FN_PAIR   = 2'd2,
    FN_NONE   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ISSUE,
    ST_DRAIN,
    ST_HOLD
  } state_t;

  // order in which a site and its neighbours are read
  typedef enum logic [2:0] {
    STEP_CTR = 3'd0,
    STEP_XP  = 3'd1,
    STEP_XM  = 3'd2,
    STEP_YP  = 3'd3,
    STEP_YM  = 3'd4,
    STEP_ZP  = 3'd5,
    STEP_ZM  = 3'd6
  } step_t;

  // travels alongside a read in flight
  typedef struct packed {
    logic valid;
    logic centre;
  } rd_tag_t;

endpackage

[rtl/core/lse_in_if.sv]
interface lse_in_if;
  logic                                valid;
  logic                                ready;
  logic [lse_pkg::FUNC_W-1:0]          func;
  logic [lse_pkg::COORD_W-1:0]         a_x;
  logic [lse_pkg::COORD_W-1:0]         a_y;
  logic [lse_pkg::COORD_W-1:0]         a_z;
  logic [lse_pkg::COORD_W-1:0]         b_x;
  logic [lse_pkg::COORD_W-1:0]         b_y;
  logic [lse_pkg::COORD_W-1:0]         b_z;
  logic signed [lse_pkg::SPIN_W-1:0]   spin_value;

  modport source (output valid, func, a_x, a_y, a_z, b_x, b_y, b_z, spin_value,
                  input ready);
  modport sink   (input valid, func, a_x, a_y, a_z, b_x, b_y, b_z, spin_value,
                  output ready);
endinterface

[rtl/core/lse_out_if.sv]
interface lse_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [lse_pkg::ENERGY_W-1:0] energy;

  modport source (output valid, energy, input ready);
  modport sink   (input valid, energy, output ready);
endinterface

[rtl/core/lattice_site_energy.sv]
// Channel  Dir  Word                                        Accepted when
// in_ch    in   func, a_x/y/z, b_x/y/z, spin_value          valid & ready
// out_ch   out  energy (signed Q12.8, 20 bits)              valid & ready
// cfg_*    in   cfg_index, cfg_data                         cfg_we
//
// Spin write: written into the spin store on the accept edge.
// Query: R reads per site, R = 5 (2D) or 7 (3D), issued through the single read
//   port of the spin store, one spin per cycle.
// Reset: a clearing pass writes every store entry, MAX_SIDE^3 of them (4096 at
//   the default), to zero; in_ch.ready stays low meanwhile, config is taken.
// A waiting result sits in the output register; a further query stalls at its end
//   until that word leaves.
module lattice_site_energy #(
  parameter int MAX_SIDE = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  lse_in_if.sink                               in_ch,
  lse_out_if.source                            out_ch,
  input  logic                                 cfg_we,
  input  logic [lse_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_SIDE * MAX_SIDE * MAX_SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int SW    = lse_pkg::SIZE_W;    // neighbour coordinates reach size - 1
  localparam int CW    = lse_pkg::COORD_W;
  localparam int EW    = lse_pkg::ENERGY_W;
  localparam int PW    = lse_pkg::SPIN_W;

  // effective size: 0 acts as 1, above MAX_SIDE acts as MAX_SIDE
  function automatic logic [SW-1:0] eff_size(input logic [SW-1:0] raw);
    logic [SW-1:0] r;
    if (raw == '0) begin
      r = SW'(1);
    end else if (int'(raw) > MAX_SIDE) begin
      r = SW'(MAX_SIDE);
    end else begin
      r = raw;
    end
    return r;
  endfunction

  function automatic logic [CW-1:0] clamp_coord(input logic [CW-1:0] c,
                                                input logic [SW-1:0] n);
    logic [CW-1:0] r;
    if (SW'(c) >= n) begin
      r = CW'(n - SW'(1));
    end else begin
      r = c;
    end
    return r;
  endfunction

  function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] c,
                                             input logic [SW-1:0] n);
    logic [SW-1:0] p;
    p = c + SW'(1);
    return (p == n) ? '0 : p;
  endfunction

  function automatic logic [SW-1:0] wrap_dec(input logic [SW-1:0] c,
                                             input logic [SW-1:0] n);
    return (c == '0) ? (n - SW'(1)) : (c - SW'(1));
  endfunction

  // z-major address, same layout whatever the configured sizes
  function automatic logic [AW-1:0] site_addr(input logic [SW-1:0] x,
                                              input logic [SW-1:0] y,
                                              input logic [SW-1:0] z);
    return AW'(z) * AW'(MAX_SIDE * MAX_SIDE) + AW'(y) * AW'(MAX_SIDE) + AW'(x);
  endfunction

  // negated pair term: -(ss + k*ss*ss) in Q12.8
  function automatic logic signed [EW-1:0] pair_term(
      input logic signed [PW-1:0] s, input logic signed [PW-1:0] n,
      input logic signed [lse_pkg::K_W-1:0] k);
    logic signed [EW-1:0] k_ext;
    logic signed [EW-1:0] r;
    k_ext = EW'(k);
    if (s == lse_pkg::SPIN_ZERO || n == lse_pkg::SPIN_ZERO) begin
      r = '0;
    end else if (s[PW-1] == n[PW-1]) begin
      r = -lse_pkg::Q_ONE - k_ext;
    end else begin
      r = lse_pkg::Q_ONE - k_ext;
    end
    return r;
  endfunction

  // ---------------- configuration (stored as effective sizes)
  logic [SW-1:0]                        nx_r, ny_r, nz_r;
  logic signed [lse_pkg::K_W-1:0]       k_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nx_r <= eff_size(lse_pkg::SIZE_X_RST);
      ny_r <= eff_size(lse_pkg::SIZE_Y_RST);
      nz_r <= eff_size(lse_pkg::SIZE_Z_RST);
      k_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lse_pkg::REG_SIZE_X:     nx_r <= eff_size(cfg_data[SW-1:0]);
        lse_pkg::REG_SIZE_Y:     ny_r <= eff_size(cfg_data[SW-1:0]);
        lse_pkg::REG_SIZE_Z:     nz_r <= eff_size(cfg_data[SW-1:0]);
        lse_pkg::REG_COUPLING_K: k_r  <= cfg_data[lse_pkg::K_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sequencer state
  lse_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   clr_addr_r;
  logic            clr_last;

  logic            in_acc;
  logic            is_query;
  logic            is_write;

  logic [CW-1:0]   ax_r, ay_r, az_r, bx_r, by_r, bz_r;
  logic            pair_r;
  lse_pkg::step_t  step_r;
  lse_pkg::step_t  last_step;
  logic            site_r;
  logic            issue_last;

  lse_pkg::rd_tag_t tag_r, tag_nxt;
  logic signed [PW-1:0] centre_r, centre_nxt;
  logic signed [EW-1:0] acc_r, acc_nxt;

  logic            out_valid_r;
  logic signed [EW-1:0] out_energy_r;
  logic            slot_free;
  logic            out_load;

  // spin store port signals
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [PW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [PW-1:0]   ram_rdata;

  // current read site, widened for wrap arithmetic
  logic [SW-1:0]   cx, cy, cz;
  logic [SW-1:0]   rx, ry, rz;

  logic [CW-1:0]   wx, wy, wz;
  logic signed [PW-1:0] wspin;

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign is_query = (in_ch.func == lse_pkg::FN_ENERGY) || (in_ch.func == lse_pkg::FN_PAIR);
  assign is_write = (in_ch.func == lse_pkg::FN_WRITE);
  assign clr_last = (clr_addr_r == AW'(DEPTH - 1));

  assign last_step  = (nz_r > SW'(1)) ? lse_pkg::STEP_ZM : lse_pkg::STEP_YM;
  assign issue_last = (step_r == last_step) && (site_r || !pair_r);

  assign slot_free = !out_valid_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lse_pkg::ST_CLEAR: if (clr_last) state_nxt = lse_pkg::ST_IDLE;
      lse_pkg::ST_IDLE:  if (in_acc && is_query) state_nxt = lse_pkg::ST_ISSUE;
      lse_pkg::ST_ISSUE: if (issue_last) state_nxt = lse_pkg::ST_DRAIN;
      lse_pkg::ST_DRAIN: state_nxt = slot_free ? lse_pkg::ST_IDLE : lse_pkg::ST_HOLD;
      lse_pkg::ST_HOLD:  if (slot_free) state_nxt = lse_pkg::ST_IDLE;
      default:           state_nxt = lse_pkg::ST_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    in_ch.ready = 1'b0;
    out_load    = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = clr_addr_r;
    ram_wdata   = lse_pkg::SPIN_ZERO;
    case (state_r)
      lse_pkg::ST_CLEAR: begin
        ram_we = 1'b1;
      end
      lse_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_we      = in_acc && is_write;
        ram_waddr   = site_addr(SW'(wx), SW'(wy), SW'(wz));
        ram_wdata   = wspin;
      end
      lse_pkg::ST_DRAIN,
      lse_pkg::ST_HOLD: begin
        out_load = slot_free;
      end
      default: ;
    endcase
  end

  // clamped write site and saturated spin
  always_comb begin
    wx = clamp_coord(in_ch.a_x, nx_r);
    wy = clamp_coord(in_ch.a_y, ny_r);
    wz = clamp_coord(in_ch.a_z, nz_r);
    case (in_ch.spin_value)
      lse_pkg::SPIN_POS:  wspin = lse_pkg::SPIN_POS;
      lse_pkg::SPIN_ZERO: wspin = lse_pkg::SPIN_ZERO;
      default:            wspin = lse_pkg::SPIN_NEG;  // -1 and -2 both
    endcase
  end

  // read address for the current step
  always_comb begin
    cx = site_r ? SW'(bx_r) : SW'(ax_r);
    cy = site_r ? SW'(by_r) : SW'(ay_r);
    cz = site_r ? SW'(bz_r) : SW'(az_r);
    rx = cx;
    ry = cy;
    rz = cz;
    case (step_r)
      lse_pkg::STEP_XP: rx = wrap_inc(cx, nx_r);
      lse_pkg::STEP_XM: rx = wrap_dec(cx, nx_r);
      lse_pkg::STEP_YP: ry = wrap_inc(cy, ny_r);
      lse_pkg::STEP_YM: ry = wrap_dec(cy, ny_r);
      lse_pkg::STEP_ZP: rz = wrap_inc(cz, nz_r);
      lse_pkg::STEP_ZM: rz = wrap_dec(cz, nz_r);
      default: ;
    endcase
    ram_raddr = site_addr(rx, ry, rz);
  end

  // data returning from the store; a new query clears the sum
  always_comb begin
    tag_nxt        = '0;
    tag_nxt.valid  = (state_r == lse_pkg::ST_ISSUE);
    tag_nxt.centre = (step_r == lse_pkg::STEP_CTR);

    centre_nxt = centre_r;
    acc_nxt    = acc_r;
    if (in_acc && is_query) begin
      acc_nxt = '0;
    end else if (tag_r.valid) begin
      if (tag_r.centre) begin
        centre_nxt = ram_rdata;
      end else begin
        acc_nxt = acc_r + pair_term(centre_r, ram_rdata, k_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lse_pkg::ST_CLEAR;
      clr_addr_r  <= '0;
      tag_r       <= '0;
      out_valid_r <= 1'b0;
      step_r      <= lse_pkg::STEP_CTR;
      site_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      tag_r   <= tag_nxt;
      if (state_r == lse_pkg::ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == lse_pkg::ST_IDLE) begin
        step_r <= lse_pkg::STEP_CTR;
        site_r <= 1'b0;
      end else if (state_r == lse_pkg::ST_ISSUE) begin
        if (step_r == last_step) begin
          step_r <= lse_pkg::STEP_CTR;
          site_r <= 1'b1;
        end else begin
          step_r <= lse_pkg::step_t'(step_r + 3'd1);
        end
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    centre_r <= centre_nxt;
    acc_r    <= acc_nxt;
    if (in_acc && is_query) begin
      pair_r <= (in_ch.func == lse_pkg::FN_PAIR);
      ax_r   <= clamp_coord(in_ch.a_x, nx_r);
      ay_r   <= clamp_coord(in_ch.a_y, ny_r);
      az_r   <= clamp_coord(in_ch.a_z, nz_r);
      bx_r   <= clamp_coord(in_ch.b_x, nx_r);
      by_r   <= clamp_coord(in_ch.b_y, ny_r);
      bz_r   <= clamp_coord(in_ch.b_z, nz_r);
    end
    if (out_load) begin
      out_energy_r <= acc_nxt;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.energy = out_energy_r;

  lse_ram #(
    .WIDTH (PW),
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_spin_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

[rtl/core/lse_ram.sv]
module lse_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/lse_checker.sv]
module lse_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [lse_pkg::FUNC_W-1:0]          in_func,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [lse_pkg::ENERGY_W-1:0] out_energy
);

  // store is being cleared straight after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_ready)
    else $error("input taken during clearing pass");

  // a waiting result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_energy))
    else $error("result word dropped or changed while stalled");

  // writes and the unused code never make a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid
      && (in_func == lse_pkg::FN_WRITE || in_func == lse_pkg::FN_NONE)
    |=> !out_valid)
    else $error("result after a non-query word");

  // a query blocks the input until it completes; checked right after it is taken
  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready
      && (in_func == lse_pkg::FN_ENERGY || in_func == lse_pkg::FN_PAIR)
    |=> !in_ready)
    else $error("input taken while a query runs");

endmodule

bind lattice_site_energy lse_checker u_lse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .in_func    (in_ch.func),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_energy (out_ch.energy)
);

[test/lse_energy_checker.sv]
module lse_energy_checker #(
  parameter int SIDE = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  lse_in_if                            in_ch,
  lse_out_if                           out_ch,
  input  logic                         cfg_we,
  input  logic [lse_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lse_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                           mismatches,
  output int                           awaiting
);
  import lse_pkg::*;

  // own copy of the lattice and registers
  logic signed [SPIN_W-1:0]   spins [SIDE*SIDE*SIDE];
  logic [SIZE_W-1:0]          reg_sx, reg_sy, reg_sz;
  logic signed [K_W-1:0]      reg_k;
  logic signed [ENERGY_W-1:0] due_energy [$];

  function automatic int unsigned span(logic [SIZE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > SIDE) return SIDE;
    return raw;
  endfunction

  function automatic int unsigned clamp(logic [COORD_W-1:0] c, int unsigned n);
    return (c >= n) ? n - 1 : c;
  endfunction

  function automatic int spin_at(int unsigned x, int unsigned y, int unsigned z);
    return spins[(z * SIDE + y) * SIDE + x];
  endfunction

  // one neighbour pair, already negated
  function automatic int bond(int s, int nb);
    int ss;
    int kk;
    ss = s * nb;
    kk = reg_k;
    return -(ss * Q_ONE + kk * ss * ss);
  endfunction

  function automatic int local_energy(int unsigned x, int unsigned y, int unsigned z,
                                      int unsigned nx, int unsigned ny, int unsigned nz);
    int s;
    int e;
    s = spin_at(x, y, z);
    e = bond(s, spin_at((x + 1) % nx, y, z)) + bond(s, spin_at((x + nx - 1) % nx, y, z))
      + bond(s, spin_at(x, (y + 1) % ny, z)) + bond(s, spin_at(x, (y + ny - 1) % ny, z));
    if (nz > 1)
      e += bond(s, spin_at(x, y, (z + 1) % nz)) + bond(s, spin_at(x, y, (z + nz - 1) % nz));
    return e;
  endfunction

  always @(posedge clk) begin
    func_t                      f;
    int unsigned                nx, ny, nz, ax, ay, az;
    int                         e;
    logic signed [ENERGY_W-1:0] want;
    if (!rst_n) begin
      reg_sx = SIZE_X_RST;
      reg_sy = SIZE_Y_RST;
      reg_sz = SIZE_Z_RST;
      reg_k  = '0;
      foreach (spins[i]) spins[i] = SPIN_ZERO;
      due_energy.delete();
      mismatches = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SIZE_X:     reg_sx = cfg_data[SIZE_W-1:0];
          REG_SIZE_Y:     reg_sy = cfg_data[SIZE_W-1:0];
          REG_SIZE_Z:     reg_sz = cfg_data[SIZE_W-1:0];
          REG_COUPLING_K: reg_k  = cfg_data[K_W-1:0];
          default: ;
        endcase
      end
      // outgoing word first: it can only belong to an earlier query
      if (out_ch.valid && out_ch.ready) begin
        if (due_energy.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected energy word %0d", out_ch.energy);
          mismatches++;
        end else begin
          want = due_energy.pop_front();
          if (out_ch.energy !== want) begin
            if (mismatches < 10)
              $display("energy mismatch: expected %0d got %0d", want, out_ch.energy);
            mismatches++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        f  = func_t'(in_ch.func);
        nx = span(reg_sx);
        ny = span(reg_sy);
        nz = span(reg_sz);
        ax = clamp(in_ch.a_x, nx);
        ay = clamp(in_ch.a_y, ny);
        az = clamp(in_ch.a_z, nz);
        case (f)
          FN_WRITE: begin
            case (in_ch.spin_value)
              SPIN_POS:  spins[(az * SIDE + ay) * SIDE + ax] = SPIN_POS;
              SPIN_ZERO: spins[(az * SIDE + ay) * SIDE + ax] = SPIN_ZERO;
              default:   spins[(az * SIDE + ay) * SIDE + ax] = SPIN_NEG;
            endcase
          end
          FN_ENERGY, FN_PAIR: begin
            e = local_energy(ax, ay, az, nx, ny, nz);
            if (f == FN_PAIR)
              e += local_energy(clamp(in_ch.b_x, nx), clamp(in_ch.b_y, ny),
                                clamp(in_ch.b_z, nz), nx, ny, nz);
            want = e[ENERGY_W-1:0];
            due_energy = {due_energy, want};
          end
          default: ;
        endcase
      end
    end
    awaiting = due_energy.size();
  end

endmodule

[test/tb.sv]
module tb;
  import lse_pkg::*;

  localparam int SIDE         = 16;
  // covers the longest query, with a little slack on top
  localparam int DRAIN_CYCLES = 24;
  // clearing pass over 4096 entries plus ~1050 words, each allowed a pessimistic time,
  // then several times over
  localparam int CYCLE_LIMIT  = 500000;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          mismatches;
  int          awaiting;
  int          send_idle;
  int          recv_idle;
  int unsigned cycles = 0;
  // effective lattice extents, used only to aim the coordinates
  int unsigned nx, ny, nz;

  lse_in_if  in_ch();
  lse_out_if out_ch();

  lattice_site_energy #(.MAX_SIDE(SIDE)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lse_energy_checker #(.SIDE(SIDE)) energy_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always #1 clk = ~clk;

  // receiver back-pressure: one draw per cycle, single assignment per edge
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= recv_idle);
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // size register value as the block sees it: 0 acts as 1, above SIDE as SIDE
  function automatic int unsigned extent(logic [SIZE_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > SIDE) return SIDE;
    return raw;
  endfunction

  // Coordinates bunch at both ends of the axis so that wrapped neighbours
  // are usually occupied; a fifth are fully random and so often clamped.
  function automatic logic [COORD_W-1:0] pick_coord(int unsigned n);
    int unsigned w;
    w = (n < 3) ? n : 3;
    case ($urandom_range(9))
      0, 1:       return COORD_W'($urandom_range(15));
      2, 3, 4, 5: return COORD_W'($urandom_range(w - 1));
      default:    return COORD_W'(n - 1 - $urandom_range(w - 1));
    endcase
  endfunction

  // Present one word and hold it until taken. Gaps are drawn per cycle
  // before the word goes up; valid is never dropped and raised in one step.
  task automatic issue(input func_t f,
                       input logic [COORD_W-1:0] ax, input logic [COORD_W-1:0] ay,
                       input logic [COORD_W-1:0] az, input logic [COORD_W-1:0] bx,
                       input logic [COORD_W-1:0] by, input logic [COORD_W-1:0] bz,
                       input logic [SPIN_W-1:0] sv);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.func       <= f;
    in_ch.a_x        <= ax;
    in_ch.a_y        <= ay;
    in_ch.a_z        <= az;
    in_ch.b_x        <= bx;
    in_ch.b_y        <= by;
    in_ch.b_z        <= bz;
    in_ch.spin_value <= sv;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Hold off until every energy word is back, then let a write or an
  // unused-code word still in the block finish.
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // four back-to-back register writes; cfg_we drops once, after the last
  task automatic set_lattice(input logic [CFG_DATA_W-1:0] rx, input logic [CFG_DATA_W-1:0] ry,
                             input logic [CFG_DATA_W-1:0] rz, input logic [CFG_DATA_W-1:0] rk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIZE_X;
    cfg_data  <= rx;
    @(posedge clk);
    cfg_index <= REG_SIZE_Y;
    cfg_data  <= ry;
    @(posedge clk);
    cfg_index <= REG_SIZE_Z;
    cfg_data  <= rz;
    @(posedge clk);
    cfg_index <= REG_COUPLING_K;
    cfg_data  <= rk;
    @(posedge clk);
    cfg_we <= 1'b0;
    nx = extent(rx[SIZE_W-1:0]);
    ny = extent(ry[SIZE_W-1:0]);
    nz = extent(rz[SIZE_W-1:0]);
  endtask

  // Mixed traffic: mostly spin writes and queries aimed at the populated
  // corners, a sprinkling of unused-code words. spin_value is all four
  // patterns, the -2 pattern included.
  task automatic random_items(input int count);
    int unsigned roll;
    func_t       f;
    repeat (count) begin
      roll = $urandom_range(99);
      f = (roll < 45) ? FN_WRITE : (roll < 70) ? FN_ENERGY : (roll < 95) ? FN_PAIR : FN_NONE;
      issue(f, pick_coord(nx), pick_coord(ny), pick_coord(nz),
            pick_coord(nx), pick_coord(ny), pick_coord(nz), SPIN_W'($urandom_range(3)));
    end
  endtask

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.func       = FN_NONE;
    in_ch.a_x        = '0;
    in_ch.a_y        = '0;
    in_ch.a_z        = '0;
    in_ch.b_x        = '0;
    in_ch.b_y        = '0;
    in_ch.b_z        = '0;
    in_ch.spin_value = SPIN_ZERO;
    cfg_we           = 1'b0;
    cfg_index        = REG_SIZE_X;
    cfg_data         = '0;
    send_idle        = 28;
    recv_idle        = 49;
    nx               = SIDE;
    ny               = SIDE;
    nz               = 1;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    // words simply wait out the clearing pass behind in_ch.ready

    // --- directed, reset lattice 16x16x1, k = 0 ---
    issue(FN_WRITE,  0,  0,  0, 0, 0, 0, SPIN_POS);
    issue(FN_WRITE, 15,  0,  0, 0, 0, 0, SPIN_NEG);   // x- neighbour of the origin via wrap
    issue(FN_WRITE,  0, 15,  0, 0, 0, 0, 2'b10);      // -2 pattern saturates to -1
    issue(FN_WRITE,  1,  0,  0, 0, 0, 0, SPIN_POS);
    issue(FN_ENERGY, 0,  0,  0, 0, 0, 0, SPIN_ZERO);
    issue(FN_ENERGY, 0,  0, 15, 0, 0, 0, SPIN_ZERO);  // z clamps to 0 on a flat lattice
    issue(FN_PAIR,   0,  0,  0, 15, 15, 15, SPIN_ZERO);
    issue(FN_NONE,  15, 15, 15, 15, 15, 15, SPIN_NEG); // unused code: no word back
    issue(FN_WRITE,  0,  0,  0, 0, 0, 0, SPIN_ZERO);  // site emptied again
    issue(FN_PAIR,  15,  0,  0, 0, 15, 0, SPIN_ZERO);
    issue(FN_ENERGY, 1,  0,  0, 0, 0, 0, SPIN_ZERO);

    // --- directed, 2x2x2 checkerboard: every neighbour counted twice ---
    // with k at its most negative this gives the largest positive energy
    settle();
    set_lattice(2, 2, 2, 16'h8000);
    for (int z = 0; z < 2; z++)
      for (int y = 0; y < 2; y++)
        for (int x = 0; x < 2; x++)
          issue(FN_WRITE, COORD_W'(x), COORD_W'(y), COORD_W'(z), 0, 0, 0,
                ((x + y + z) % 2 != 0) ? SPIN_NEG : SPIN_POS);
    issue(FN_PAIR,    0,  0,  0, 1, 1, 1, SPIN_ZERO);
    issue(FN_ENERGY, 15, 15, 15, 0, 0, 0, SPIN_ZERO); // clamps to the far corner
    settle();
    set_lattice(2, 2, 2, 16'h7FFF);                 // k at its most positive
    issue(FN_PAIR,    0,  0,  0, 1, 1, 1, SPIN_ZERO);

    // --- random phases: two settings per idling mode ---
    for (int p = 0; p < 6; p++) begin
      settle();
      if (p == 2) begin
        send_idle = 49;
        recv_idle = 28;
      end else if (p == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (p)
        0: set_lattice(5, 3, 4, 16'h0180);
        1: set_lattice(1, 16, 2, 16'hFFC0);           // x of one site: self-neighbour
        2: set_lattice(16, 16, 16, 16'h7FFF);         // full 3D store
        3: set_lattice(0, 2, 31, 16'h8000);           // 0 acts as 1, 31 as 16
        4: set_lattice(16'hFFE7, 3, 1, 16'($urandom)); // upper data bits ignored: x = 7
        default: set_lattice(8, 8, 8, 16'($urandom));
      endcase
      random_items(171);
    end

    settle();
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
